FILE: design/assert_macros.svh
// Assertion helpers. The bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LPHS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPHS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/lphs_pkg.sv
package lphs_pkg;

  localparam int SLOTS   = 1024;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int KEY_W   = 64;
  localparam int MARK_W  = 2;
  localparam int WORD_W  = MARK_W + KEY_W;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int OUT_FIELDS_W = SLOT_W + 2 * CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // request codes on the input side
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PROBE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_PROBE,
    CMD_NOP
  } cmd_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_TAKEN = 2'd1,
    MARK_STALE = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
  } q_item_t;

  // front to back: head of the request queue
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } fq_t;

  // back to front: queue pop and clearing pass in progress
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_stat_t;

endpackage

FILE: design/lphs_ram.sv
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lphs_front.sv
`include "assert_macros.svh"

module lphs_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lphs_pkg::KEY_W-1:0]      in_tdata,
  input  logic [1:0]                      in_tuser,
  output lphs_pkg::fq_t                   fq,
  input  lphs_pkg::bk_stat_t              bk_stat
);

  lphs_pkg::q_item_t             q_r [lphs_pkg::QDEPTH];
  logic [lphs_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lphs_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lphs_pkg::QCNT_W-1:0]   count_r, count_nxt;
  lphs_pkg::q_item_t             item;
  logic                          push;
  logic                          pop;

  always_comb begin
    item.key = in_tdata;
    case (in_tuser)
      lphs_pkg::REQ_INSERT: item.cmd = lphs_pkg::CMD_INSERT;
      lphs_pkg::REQ_REMOVE: item.cmd = lphs_pkg::CMD_REMOVE;
      lphs_pkg::REQ_PROBE:  item.cmd = lphs_pkg::CMD_PROBE;
      default:              item.cmd = lphs_pkg::CMD_NOP;
    endcase
  end

  assign in_tready = (count_r != lphs_pkg::QCNT_W'(lphs_pkg::QDEPTH)) && !bk_stat.clearing;
  assign push      = in_tvalid && in_tready;
  assign pop       = bk_stat.pop && (count_r != '0);

  assign fq.valid = (count_r != '0);
  assign fq.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  `LPHS_ASSERT(a_cnt_bound, clk, rst_n, count_r <= lphs_pkg::QCNT_W'(lphs_pkg::QDEPTH), "queue count above depth")
  `LPHS_ASSERT(a_no_take_clr, clk, rst_n, bk_stat.clearing |-> !in_tready, "request taken during clearing pass")
  `LPHS_ASSERT(a_pop_valid, clk, rst_n, bk_stat.pop |-> fq.valid, "pop from empty queue")

endmodule

FILE: design/lphs_back.sv
`include "assert_macros.svh"

module lphs_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lphs_pkg::fq_t                   fq,
  output lphs_pkg::bk_stat_t              bk_stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lphs_pkg::status_t               out_status,
  output logic [lphs_pkg::SLOT_W-1:0]     out_slot,
  output logic [lphs_pkg::CNT_W-1:0]      out_live,
  output logic [lphs_pkg::CNT_W-1:0]      out_stale
);

  localparam int SLOT_W = lphs_pkg::SLOT_W;
  localparam int CNT_W  = lphs_pkg::CNT_W;
  localparam int KEY_W  = lphs_pkg::KEY_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(lphs_pkg::SLOTS - 1);

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                    state_r, state_nxt;
  lphs_pkg::cmd_t            cmd_r, cmd_nxt;
  logic [KEY_W-1:0]          key_r, key_nxt;
  logic [SLOT_W-1:0]         addr_r, addr_nxt;
  logic [SLOT_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]          live_r, live_nxt;
  logic [CNT_W-1:0]          stale_r, stale_nxt;
  logic                      out_valid_r, out_valid_nxt;
  lphs_pkg::status_t         out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]         out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]          out_live_r, out_live_nxt;
  logic [CNT_W-1:0]          out_stale_r, out_stale_nxt;

  logic                          ram_we;
  logic [SLOT_W-1:0]             ram_waddr;
  logic [lphs_pkg::WORD_W-1:0]   ram_wdata;
  logic [SLOT_W-1:0]             ram_raddr;
  logic [lphs_pkg::WORD_W-1:0]   ram_rdata;

  lphs_pkg::mark_t           mark;
  logic [KEY_W-1:0]          slot_k;
  logic                      last;
  logic                      fin;
  lphs_pkg::status_t         fin_status;
  logic [SLOT_W-1:0]         fin_slot;
  logic                      pop;

  // one word per slot: mark above key
  lphs_ram #(
    .WIDTH (lphs_pkg::WORD_W),
    .DEPTH (lphs_pkg::SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mark   = lphs_pkg::mark_t'(ram_rdata[KEY_W +: lphs_pkg::MARK_W]);
  assign slot_k = ram_rdata[KEY_W-1:0];
  assign last   = (n_r == LAST_SLOT);

  assign bk_stat.pop      = pop;
  assign bk_stat.clearing = (state_r == ST_CLR);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    addr_nxt       = addr_r;
    n_nxt          = n_r;
    live_nxt       = live_r;
    stale_nxt      = stale_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_live_nxt   = out_live_r;
    out_stale_nxt  = out_stale_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '0;
    ram_raddr      = addr_r;
    pop            = 1'b0;
    fin            = 1'b0;
    fin_status     = lphs_pkg::STAT_ABSENT;
    fin_slot       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // the output register is free by the time a walk can end
        if (fq.valid && (!out_valid_r || out_ready)) begin
          pop       = 1'b1;
          cmd_nxt   = fq.item.cmd;
          key_nxt   = fq.item.key;
          addr_nxt  = fq.item.key[SLOT_W-1:0];
          ram_raddr = fq.item.key[SLOT_W-1:0];
          n_nxt     = '0;
          if (fq.item.cmd == lphs_pkg::CMD_NOP) begin
            fin = 1'b1;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // read data holds slot addr_r; fetch the next one meanwhile
        ram_raddr = addr_r + 1'b1;
        addr_nxt  = addr_r + 1'b1;
        n_nxt     = n_r + 1'b1;
        case (cmd_r)
          lphs_pkg::CMD_INSERT: begin
            if (mark != lphs_pkg::MARK_TAKEN) begin
              ram_we    = 1'b1;
              ram_wdata = {lphs_pkg::MARK_TAKEN, key_r};
              if (mark == lphs_pkg::MARK_STALE && stale_r != '0) begin
                stale_nxt = stale_r - 1'b1;
              end
              live_nxt   = live_r + 1'b1;
              fin        = 1'b1;
              fin_status = lphs_pkg::STAT_OK;
              fin_slot   = addr_r;
            end else if (slot_k == key_r) begin
              fin        = 1'b1;
              fin_status = lphs_pkg::STAT_OK;
              fin_slot   = addr_r;
            end else if (last) begin
              fin        = 1'b1;
              fin_status = lphs_pkg::STAT_FULL;
            end
          end
          lphs_pkg::CMD_REMOVE, lphs_pkg::CMD_PROBE: begin
            if (mark == lphs_pkg::MARK_EMPTY) begin
              fin = 1'b1;
            end else if (mark == lphs_pkg::MARK_TAKEN && slot_k == key_r) begin
              fin        = 1'b1;
              fin_status = lphs_pkg::STAT_OK;
              fin_slot   = addr_r;
              if (cmd_r == lphs_pkg::CMD_REMOVE) begin
                ram_we    = 1'b1;
                ram_wdata = {lphs_pkg::MARK_STALE, key_r};
                if (live_r != '0) begin
                  live_nxt = live_r - 1'b1;
                end
                stale_nxt = stale_r + 1'b1;
              end
            end else if (last) begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_slot_nxt   = fin_slot;
      out_live_nxt   = live_nxt;
      out_stale_nxt  = stale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      addr_r      <= '0;
      live_r      <= '0;
      stale_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      live_r      <= live_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_live_r   <= out_live_nxt;
    out_stale_r  <= out_stale_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_live   = out_live_r;
  assign out_stale  = out_stale_r;

  `LPHS_ASSERT(a_we_state, clk, rst_n, ram_we |-> (state_r == ST_CLR || state_r == ST_WALK), "slot write outside walk or clear")
  `LPHS_ASSERT(a_cnt_sum, clk, rst_n, ({1'b0, live_r} + {1'b0, stale_r}) <= (CNT_W + 1)'(lphs_pkg::SLOTS), "live plus stale exceeds slots")
  `LPHS_ASSERT(a_pop_free, clk, rst_n, pop |-> (!out_valid_r || out_ready), "request started with result pending")
  `LPHS_ASSERT(a_walk_out, clk, rst_n, (state_r == ST_WALK) |-> !out_valid_r, "result pending during walk")

endmodule

FILE: design/linear_probe_hash_set.sv
// Linear-probing hash set of 64-bit keys with tombstones, 1024 slots.
// Request channel (in_*): in_tuser carries the request kind (0 insert,
// 1 remove, 2 probe, 3 ignored), in_tdata the key. Result channel (out_*):
// out_tuser carries the status (0 done/found, 1 absent, 2 full), out_tdata
// the slot and the live and tombstone counts after the request.
// After reset the slot memory is swept to empty, one slot a cycle;
// in_tready stays low during the sweep.
// Requests sit in a two-deep queue; the walker then visits one slot per
// cycle through the single read port of the slot memory. A walk visits
// from 1 up to 1024 slots; an ignored kind is finished without a walk.
// The result is held in an output register until taken; while it waits,
// up to two further requests are queued, and the next request is taken
// from the queue in the cycle the result is taken.
module linear_probe_hash_set (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [lphs_pkg::KEY_W-1:0]            in_tdata,   // key
  input  logic [1:0]                            in_tuser,   // req_type
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [lphs_pkg::OUT_TDATA_W-1:0]      out_tdata,  // slot, live_count, stale_count
  output logic [1:0]                            out_tuser   // status
);

  lphs_pkg::fq_t                    fq;
  lphs_pkg::bk_stat_t               bk_stat;
  lphs_pkg::status_t                status;
  logic [lphs_pkg::SLOT_W-1:0]      slot;
  logic [lphs_pkg::CNT_W-1:0]       live;
  logic [lphs_pkg::CNT_W-1:0]       stale;

  lphs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fq        (fq),
    .bk_stat   (bk_stat)
  );

  lphs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fq         (fq),
    .bk_stat    (bk_stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_slot   (slot),
    .out_live   (live),
    .out_stale  (stale)
  );

  assign out_tuser = status;
  assign out_tdata = lphs_pkg::OUT_TDATA_W'({stale, live, slot});

endmodule
